### src/text_screen_buffer_defines.svh
// Assertion macros shared by the screen buffer modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef TEXT_SCREEN_BUFFER_DEFINES_SVH
`define TEXT_SCREEN_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tsb_pkg.sv
// Shared types and constants for the text screen buffer.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tsb_pkg;

  // Operation codes carried on the mode input.
  localparam logic [2:0] MODE_PEEK   = 3'd0;
  localparam logic [2:0] MODE_POKE   = 3'd1;
  localparam logic [2:0] MODE_WRITE  = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_SCROLL = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  // Status codes returned with every result.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ADDR  = 2'd1;
  localparam logic [1:0] STATUS_VALUE = 2'd2;

  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam int          BYTE_MAX     = 255;
  localparam logic [15:0] BASE_DEFAULT = 16'h3C00;

  // Source of the read data for a single-access request.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_MEM,
    RD_SPACE
  } tsb_rd_sel_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RESP,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL
  } tsb_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ptr_clr;
    logic ptr_bot;
    logic ptr_inc;
    logic scroll_wr;
    logic fill_wr;
    logic emit_single;
    logic emit_zero;
  } tsb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_move_end;
    logic at_end;
  } tsb_stat_t;

endpackage

`default_nettype wire

### src/text_screen_buffer.sv
// Text screen buffer, ROWS by COLS bytes, with a start/busy/done request
// interface. Results appear on read_data and status for exactly one cycle
// with done high and cannot be held off by the receiver. Peek, poke, write
// and read by row/column pass through a response state: the memory access is
// issued at the accepting edge and the registered read data is turned into
// the result at the end of the response state, and done rises with it. Scroll
// moves rows 1 to ROWS-1 up by one row, reading each moved byte in the read
// state and writing it in the write state, then fills the bottom row with
// spaces; clear fills the whole store with spaces. After reset busy stays
// high while the store is filled with spaces; the base address may be written then.
// Depends on tsb_pkg, tsb_ctrl and tsb_datapath.
`default_nettype none

module text_screen_buffer import tsb_pkg::*; #(
  parameter int ROWS = 24,
  parameter int COLS = 80
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        mode,
  input  wire logic [15:0]       address,
  input  wire logic signed [9:0] value,
  input  wire logic [5:0]        row,
  input  wire logic [6:0]        col,
  input  wire logic [7:0]        char_code,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  output logic                   done,
  output logic [7:0]             read_data,
  output logic [1:0]             status
);

  tsb_cmd_t  cmd;
  tsb_stat_t stat;

  // Sequencing of requests and sweeps.
  tsb_ctrl #(
    .ROWS(ROWS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memory, address decode and result registers.
  tsb_datapath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .address     (address),
    .value       (value),
    .row         (row),
    .col         (col),
    .char_code   (char_code),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .read_data   (read_data),
    .status      (status)
  );

endmodule

`default_nettype wire

### src/tsb_ctrl.sv
// Controller state machine for the text screen buffer.
// Depends on tsb_pkg and text_screen_buffer_defines.svh.
`default_nettype none
`include "text_screen_buffer_defines.svh"

module tsb_ctrl import tsb_pkg::*; #(
  parameter int ROWS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [2:0] mode,
  input  wire tsb_stat_t  stat,
  output tsb_cmd_t        cmd,
  output logic            busy
);

  tsb_state_t state;
  tsb_state_t state_next;
  logic       accept;
  logic       is_scroll;
  logic       is_clear;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && (state == ST_IDLE);
  assign is_scroll = (mode == MODE_SCROLL);
  assign is_clear  = (mode == MODE_CLEAR);

  // State register; reset starts the pass that fills the store with spaces.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (stat.at_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (is_scroll) begin
            state_next = (ROWS > 1) ? ST_SCROLL_RD : ST_FILL;
          end else if (is_clear) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      ST_SCROLL_RD: begin
        state_next = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        state_next = stat.at_move_end ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        if (stat.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_wr = 1'b1;
        cmd.ptr_inc = !stat.at_end;
      end
      ST_IDLE: begin
        cmd.accept = accept;
        if (accept && is_scroll) begin
          if (ROWS > 1) begin
            cmd.ptr_clr = 1'b1;
          end else begin
            cmd.ptr_bot = 1'b1;
          end
        end else if (accept && is_clear) begin
          cmd.ptr_clr = 1'b1;
        end
      end
      ST_RESP: begin
        cmd.emit_single = 1'b1;
      end
      ST_SCROLL_RD: begin
        cmd = '0;
      end
      ST_SCROLL_WR: begin
        cmd.scroll_wr = 1'b1;
        if (stat.at_move_end) begin
          cmd.ptr_bot = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.at_end) begin
          cmd.emit_zero = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Single accesses pass through the response state and then return to idle.
  `TSB_ASSERT_NEXT(a_single_to_resp, accept && !is_scroll && !is_clear, state == ST_RESP, "single request did not enter the response state")
  `TSB_ASSERT_NEXT(a_resp_to_idle, state == ST_RESP, state == ST_IDLE, "response state lasted more than one cycle")
  `TSB_ASSERT_NEXT(a_scroll_to_fill, (state == ST_SCROLL_WR) && stat.at_move_end, state == ST_FILL, "scroll did not continue with the bottom row fill")

endmodule

`default_nettype wire

### src/tsb_datapath.sv
// Datapath for the text screen buffer: screen memory, sweep pointer,
// address decode, base register and result registers. Depends on tsb_pkg.
`default_nettype none
`include "text_screen_buffer_defines.svh"

module tsb_datapath import tsb_pkg::*; #(
  parameter int ROWS = 24,
  parameter int COLS = 80
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsb_cmd_t          cmd,
  output tsb_stat_t              stat,
  input  wire logic [2:0]        mode,
  input  wire logic [15:0]       address,
  input  wire logic signed [9:0] value,
  input  wire logic [5:0]        row,
  input  wire logic [6:0]        col,
  input  wire logic [7:0]        char_code,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  output logic                   done,
  output logic [7:0]             read_data,
  output logic [1:0]             status
);

  localparam int N  = ROWS * COLS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;

  logic [7:0]    mem [N];
  logic [7:0]    mem_q;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_up;
  logic [15:0]   base_address;
  tsb_rd_sel_t   rd_sel;
  logic [1:0]    st_hold;

  logic [16:0]   win_diff;
  logic          win_hit;
  logic [15:0]   rc_lin;
  logic          pos_ok;
  logic          val_ok;

  logic          acc_wr;
  logic [AW-1:0] acc_off;
  logic [7:0]    acc_wdata;
  tsb_rd_sel_t   acc_sel;
  logic [1:0]    acc_st;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Base address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_DEFAULT;
    end else if (cfg_wr_en) begin
      base_address <= cfg_wr_data;
    end
  end

  // Window check: the bus address must lie in base .. base + N - 1, no wrap.
  assign win_diff = {1'b0, address} - {1'b0, base_address};
  assign win_hit  = !win_diff[16] && (win_diff[15:0] < 16'(N));

  // Row/column position and poke value checks.
  assign rc_lin = 16'(row) * 16'(COLS) + 16'(col);
  assign pos_ok = (16'(row) < 16'(ROWS)) && (16'(col) < 16'(COLS));
  assign val_ok = !value[9] && (value[8:0] <= 9'(BYTE_MAX));

  // Decode of a single-access request.
  always_comb begin
    acc_wr    = 1'b0;
    acc_off   = win_diff[AW-1:0];
    acc_wdata = value[7:0];
    acc_sel   = RD_ZERO;
    acc_st    = STATUS_OK;
    case (mode)
      MODE_PEEK: begin
        if (win_hit) begin
          acc_sel = RD_MEM;
        end else begin
          acc_st = STATUS_ADDR;
        end
      end
      MODE_POKE: begin
        if (!win_hit) begin
          acc_st = STATUS_ADDR;
        end else if (!val_ok) begin
          acc_st = STATUS_VALUE;
        end else begin
          acc_wr = 1'b1;
        end
      end
      MODE_WRITE: begin
        acc_off   = rc_lin[AW-1:0];
        acc_wdata = char_code;
        acc_wr    = pos_ok;
      end
      MODE_READ: begin
        acc_off = rc_lin[AW-1:0];
        acc_sel = pos_ok ? RD_MEM : RD_SPACE;
      end
      default: begin
        acc_wr = 1'b0;
      end
    endcase
  end

  // Memory port selection: request access, scroll copy or space fill.
  assign ptr_up    = AW'({1'b0, ptr} + (AW + 1)'(COLS));
  assign mem_raddr = cmd.accept ? acc_off : ptr_up;
  assign mem_we    = (cmd.accept && acc_wr) || cmd.scroll_wr || cmd.fill_wr;
  assign mem_waddr = cmd.accept ? acc_off : ptr;
  always_comb begin
    if (cmd.accept) begin
      mem_wdata = acc_wdata;
    end else if (cmd.scroll_wr) begin
      mem_wdata = mem_q;
    end else begin
      mem_wdata = SPACE_CODE;
    end
  end

  // Screen memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // Sweep pointer for the reset fill, clear and scroll.
  always_ff @(posedge clk) begin
    if (rst || cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_bot) begin
      ptr <= AW'(N - COLS);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
  end

  assign stat.at_move_end = (ptr == AW'(N - COLS - 1));
  assign stat.at_end      = (ptr == AW'(N - 1));

  // Hold the decoded result of a single access until its response cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_sel  <= acc_sel;
      st_hold <= acc_st;
    end
  end

  // Result registers; done is a one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_single || cmd.emit_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      status <= st_hold;
      case (rd_sel)
        RD_MEM:   read_data <= mem_q;
        RD_SPACE: read_data <= SPACE_CODE;
        default:  read_data <= 8'h00;
      endcase
    end else if (cmd.emit_zero) begin
      status    <= STATUS_OK;
      read_data <= 8'h00;
    end
  end

  `TSB_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `TSB_ASSERT_NOW(a_err_no_data, done && (status != STATUS_OK), read_data == 8'h00, "failed request returned nonzero data")
  `TSB_ASSERT_NOW(a_ptr_range, 1'b1, ptr <= AW'(N - 1), "sweep pointer ran past the screen")

endmodule

`default_nettype wire
